>>> rtl/core/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg
// Types, register indexes and arithmetic helpers shared by the 3x3 blur core.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned FRAME_W_W    = 11;
    localparam int unsigned FRAME_H_W    = 16;
    localparam int unsigned PIX_W        = 8;
    localparam int unsigned OUT_COL_W    = 10;
    localparam int unsigned OUT_ROW_W    = 16;
    localparam int unsigned M_TDATA_W    = 40;

    // Vertical triple: [23:16] row r-2, [15:8] row r-1, [7:0] row r.
    typedef logic [3*PIX_W-1:0] triple_t;

    // One pixel's worth of window data handed to the result sequencer.
    typedef struct packed {
        triple_t                cur;       // column c
        triple_t                win0;      // column c-1
        triple_t                win1;      // column c-2
        logic [OUT_COL_W-1:0]   col;       // column c, truncated
        logic [OUT_ROW_W-1:0]   row;       // row r
        logic                   has_left;  // c >= 1
        logic                   left2;     // c >= 2
        logic                   last_col;
        logic                   has_up;    // r >= 1
        logic                   up2;       // r >= 2
        logic                   last_row;
    } job_t;

    // Vertical 1-2-1 sum of a triple. Mode 0 centers on row r-1, mode 1 on
    // row r with the bottom replicated.
    function automatic logic [9:0] col_sum(input triple_t t, input logic mode,
                                           input logic up1, input logic up2);
        logic [9:0] o;
        logic [9:0] n;
        logic [9:0] p;
        logic [9:0] top;
        logic [9:0] mid;
        logic [9:0] bot;
        o = {2'b00, t[23:16]};
        n = {2'b00, t[15:8]};
        p = {2'b00, t[7:0]};
        if (!mode) begin
            top = up2 ? o : n;
            mid = n;
            bot = p;
        end else begin
            top = up1 ? n : p;
            mid = p;
            bot = p;
        end
        return top + {mid[8:0], 1'b0} + bot;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/gb3_line_store.sv
// ----------------------------------------------------------------------------
// gb3_line_store
// Two line memories holding the previous two image rows, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_line_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic [gb3_pkg::PIX_W-1:0] rd_older,
    output logic [gb3_pkg::PIX_W-1:0] rd_newer,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [gb3_pkg::PIX_W-1:0] wr_older,
    input  wire logic [gb3_pkg::PIX_W-1:0] wr_newer
);
    import gb3_pkg::*;

    logic [PIX_W-1:0] older_mem [DEPTH];
    logic [PIX_W-1:0] newer_mem [DEPTH];
    logic [PIX_W-1:0] older_q_reg;
    logic [PIX_W-1:0] newer_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            older_q_reg <= older_mem[rd_addr];
            newer_q_reg <= newer_mem[rd_addr];
        end
    end

    assign rd_older = older_q_reg;
    assign rd_newer = newer_q_reg;

endmodule

`default_nettype wire

>>> rtl/core/gb3_emit.sv
// ----------------------------------------------------------------------------
// gb3_emit
// Result sequencer: walks the one to four results of a job and computes the
// blurred value of each into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_emit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  job_load,
    input  wire gb3_pkg::job_t         job_in,
    output logic                       job_take,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [gb3_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser
);
    import gb3_pkg::*;

    logic        busy_reg;
    job_t        job_reg;
    logic        mode_reg;
    logic        mode_next;
    logic        colsel_reg;
    logic        colsel_next;

    logic        m_valid_reg;
    logic [PIX_W-1:0]     m_pix_reg;
    logic [OUT_COL_W-1:0] m_col_reg;
    logic [OUT_ROW_W-1:0] m_row_reg;
    logic        m_last_reg;
    logic        m_done_reg;

    logic        fire;
    logic        more_cols;
    logic        more_rows;
    logic        is_last;
    triple_t     tl;
    triple_t     tm;
    triple_t     tr;
    logic [9:0]  sl;
    logic [9:0]  sm;
    logic [9:0]  sr;
    logic [11:0] wsum;
    logic [OUT_COL_W-1:0] x;
    logic [OUT_ROW_W-1:0] y;

    assign fire      = busy_reg && (!m_valid_reg || m_axis_tready);
    assign more_cols = !colsel_reg && job_reg.last_col;
    assign more_rows = !mode_reg && job_reg.last_row;
    assign is_last   = !more_cols && !more_rows;
    assign job_take  = !busy_reg || (fire && is_last);

    always_comb begin
        // colsel 0 is column c-1, colsel 1 is column c.
        if (!colsel_reg) begin
            tl = job_reg.left2 ? job_reg.win1 : job_reg.win0;
            tm = job_reg.win0;
            tr = job_reg.cur;
            x  = job_reg.col - OUT_COL_W'(1);
        end else begin
            tl = job_reg.has_left ? job_reg.win0 : job_reg.cur;
            tm = job_reg.cur;
            tr = job_reg.cur;
            x  = job_reg.col;
        end
        y    = mode_reg ? job_reg.row : job_reg.row - OUT_ROW_W'(1);
        sl   = col_sum(tl, mode_reg, job_reg.has_up, job_reg.up2);
        sm   = col_sum(tm, mode_reg, job_reg.has_up, job_reg.up2);
        sr   = col_sum(tr, mode_reg, job_reg.has_up, job_reg.up2);
        wsum = 12'(sl) + {1'b0, sm, 1'b0} + 12'(sr);

        if (more_cols) begin
            mode_next   = mode_reg;
            colsel_next = 1'b1;
        end else begin
            mode_next   = 1'b1;
            colsel_next = !job_reg.has_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (job_load) begin
            busy_reg <= 1'b1;
        end else if (fire && is_last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_reg    <= job_in;
            mode_reg   <= !job_in.has_up;
            colsel_reg <= !job_in.has_left;
        end else if (fire) begin
            mode_reg   <= mode_next;
            colsel_reg <= colsel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_pix_reg  <= wsum[11:4];
            m_col_reg  <= x;
            m_row_reg  <= y;
            m_last_reg <= is_last;
            m_done_reg <= is_last && job_reg.last_col && job_reg.last_row;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_row_reg, m_col_reg, m_pix_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_done_reg;

endmodule

`default_nettype wire

>>> rtl/core/gauss_blur_3x3_replicate_core.sv
// ----------------------------------------------------------------------------
// gauss_blur_3x3_replicate_core
// 3x3 binomial blur (1 2 1 / 2 4 2 / 1 2 1, divided by 16) over a raster
// stream of 8-bit pixels, with the edge pixel replicated at every border.
// ----------------------------------------------------------------------------
// Usage notes.
// Pixels enter on the s_axis channel in raster order, one per transaction.
// Blurred pixels leave on the m_axis channel together with their column and
// row. An output lags one row and one column behind the input, so a pixel
// completes the neighborhood above and to its left. At the end of a row the
// pixel also finishes the last column, and on the last row it finishes the
// row itself, so a single input causes zero to four output transactions in
// row order, then column order. tlast marks the last output caused by one
// input and tuser marks the bottom-right pixel of the frame. An input's
// first output passes the stage 1, job and output registers. Throughput is
// one transaction per cycle on both sides; the extra border outputs leave
// one per cycle and hold off the input meanwhile. The rate is set by the
// single output register of the result sequencer. Reset clears the position
// counters and the window; the line memories are not cleared and are filled
// by the first rows. When the receiver stalls, the output register holds
// its transaction, the pipeline fills and s_axis_tready drops. Width and
// height must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module gauss_blur_3x3_replicate_core #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic                              cfg_wr_en,
    input  wire logic [gb3_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [gb3_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // Input pixel stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    // Blurred pixel stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] pixel_out, [17:8] out_col,
                                             // [33:18] out_row, zero above
    output logic             m_axis_tlast,   // run_last
    output logic             m_axis_tuser    // frame_done
);
    import gb3_pkg::*;

    // Column counter width and a common width for the width comparisons.
    localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CMPW = ((CW >= FRAME_W_W) ? CW : FRAME_W_W) + 1;

    // Configuration registers.
    logic [FRAME_W_W-1:0] frame_width_reg;
    logic [FRAME_H_W-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_W_W'(640);
            frame_height_reg <= FRAME_H_W'(480);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[FRAME_W_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[FRAME_H_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept a pixel, classify its position and issue the line
    // memory read at its column.
    // ------------------------------------------------------------------
    logic [CW-1:0]        col_cnt_reg;
    logic [CW-1:0]        col_cnt_next;
    logic [FRAME_H_W-1:0] row_cnt_reg;
    logic [FRAME_H_W-1:0] row_cnt_next;
    logic [CMPW-1:0]      width_ext;
    logic [CMPW-1:0]      col_ext;
    logic [CMPW-1:0]      last_col_idx;
    logic                 at_last_col;
    logic                 at_last_row;
    logic                 s_fire;

    // Stage 1 registers.
    logic                 s1_valid_reg;
    logic [CW-1:0]        s1_addr_reg;
    logic [PIX_W-1:0]     s1_pix_reg;
    logic [OUT_COL_W-1:0] s1_col_reg;
    logic [OUT_ROW_W-1:0] s1_row_reg;
    logic                 s1_has_left_reg;
    logic                 s1_left2_reg;
    logic                 s1_last_col_reg;
    logic                 s1_has_up_reg;
    logic                 s1_up2_reg;
    logic                 s1_last_row_reg;
    logic                 s1_fwd_reg;
    logic [PIX_W-1:0]     s1_fwd_older_reg;
    logic [PIX_W-1:0]     s1_fwd_newer_reg;
    logic                 s1_adv;
    logic                 s1_empty_job;

    logic [PIX_W-1:0]     mem_older;
    logic [PIX_W-1:0]     mem_newer;
    logic [PIX_W-1:0]     eff_older;
    logic [PIX_W-1:0]     eff_newer;

    triple_t              win0_reg;
    triple_t              win1_reg;
    job_t                 job;
    logic                 job_take;

    assign width_ext = CMPW'(frame_width_reg);
    assign col_ext   = CMPW'(col_cnt_reg);

    always_comb begin
        // Width zero acts as one, widths past the line memory saturate.
        if (frame_width_reg == '0) begin
            last_col_idx = '0;
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            last_col_idx = CMPW'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = width_ext - CMPW'(1);
        end
        at_last_col = col_ext >= last_col_idx;
        // Height zero acts as one: every row is the last one.
        at_last_row = (frame_height_reg == '0) ||
                      (row_cnt_reg >= frame_height_reg - FRAME_H_W'(1));

        if (at_last_col) begin
            col_cnt_next = '0;
            row_cnt_next = at_last_row ? '0 : row_cnt_reg + FRAME_H_W'(1);
        end else begin
            col_cnt_next = col_cnt_reg + CW'(1);
            row_cnt_next = row_cnt_reg;
        end
    end

    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (s_fire) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // When the pixel ahead writes the same column in the cycle this read is
    // issued (a one-pixel-wide frame), the memory returns stale data, so its
    // write values are captured and used instead.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_addr_reg      <= col_cnt_reg;
            s1_pix_reg       <= s_axis_tdata;
            s1_col_reg       <= OUT_COL_W'(col_cnt_reg);
            s1_row_reg       <= row_cnt_reg;
            s1_has_left_reg  <= col_cnt_reg != '0;
            s1_left2_reg     <= col_ext > CMPW'(1);
            s1_last_col_reg  <= at_last_col;
            s1_has_up_reg    <= row_cnt_reg != '0;
            s1_up2_reg       <= row_cnt_reg > FRAME_H_W'(1);
            s1_last_row_reg  <= at_last_row;
            s1_fwd_reg       <= s1_valid_reg && (s1_addr_reg == col_cnt_reg);
            s1_fwd_older_reg <= eff_newer;
            s1_fwd_newer_reg <= s1_pix_reg;
        end
    end

    gb3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk     (aclk),
        .rd_en    (s_fire),
        .rd_addr  (col_cnt_reg),
        .rd_older (mem_older),
        .rd_newer (mem_newer),
        .wr_en    (s1_adv),
        .wr_addr  (s1_addr_reg),
        .wr_older (eff_newer),
        .wr_newer (s1_pix_reg)
    );

    // ------------------------------------------------------------------
    // Stage 1: form the vertical triple of the current column, shift the
    // rows down in the line memory and hand the window to the sequencer.
    // ------------------------------------------------------------------
    assign eff_older = s1_fwd_reg ? s1_fwd_older_reg : mem_older;
    assign eff_newer = s1_fwd_reg ? s1_fwd_newer_reg : mem_newer;

    always_comb begin
        job.cur      = {eff_older, eff_newer, s1_pix_reg};
        job.win0     = win0_reg;
        job.win1     = win1_reg;
        job.col      = s1_col_reg;
        job.row      = s1_row_reg;
        job.has_left = s1_has_left_reg;
        job.left2    = s1_left2_reg;
        job.last_col = s1_last_col_reg;
        job.has_up   = s1_has_up_reg;
        job.up2      = s1_up2_reg;
        job.last_row = s1_last_row_reg;
    end

    // A pixel in column 0 (not last) or row 0 (not last) completes nothing.
    assign s1_empty_job = !(s1_has_left_reg || s1_last_col_reg) ||
                          !(s1_has_up_reg || s1_last_row_reg);
    assign s1_adv       = s1_valid_reg && (s1_empty_job || job_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg <= '0;
            win1_reg <= '0;
        end else if (s1_adv) begin
            win1_reg <= win0_reg;
            win0_reg <= job.cur;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: result sequencer and output register.
    // ------------------------------------------------------------------
    gb3_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_load      (s1_adv && !s1_empty_job),
        .job_in        (job),
        .job_take      (job_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
